[sv/hspc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hspc_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int HALL_W   = 3;
    localparam int COUNT_W  = 16;
    localparam int THR_W    = 10;
    localparam int CMP_W    = 16;
    localparam int PHASE_W  = 9;
    localparam int STEP_W   = 8;
    localparam int ENTRY_W  = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;

    // step divider: dividend covers the step numerator up to 4096 * 30
    localparam int DIV_DW = 17;
    localparam int DIV_SW = COUNT_W;

    // entry * throttle
    localparam int PROD_W = ENTRY_W + THR_W;

    localparam logic [COUNT_W-1:0] STEP_LOWER  = 16'd100;
    localparam logic [COUNT_W-1:0] STEP_UPPER  = 16'd15360;
    localparam int                 STEP_FACTOR = 30;
    localparam logic [STEP_W-1:0]  STEP_MAX    = 8'd255;
    localparam logic [PHASE_W-1:0] PHASE_MASK  = 9'h1FF;

    // bridge switch bits
    localparam logic [5:0] SW_UH = 6'h20;
    localparam logic [5:0] SW_UL = 6'h10;
    localparam logic [5:0] SW_VH = 6'h08;
    localparam logic [5:0] SW_VL = 6'h04;
    localparam logic [5:0] SW_WH = 6'h02;
    localparam logic [5:0] SW_WL = 6'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_HALL    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CH_NONE = 2'd0,
        CH_W    = 2'd1,
        CH_V    = 2'd2,
        CH_U    = 2'd3
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_ROM,
        ST_TICK_MUL,
        ST_TICK_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PUSH
    } state_t;

    function automatic logic [5:0] bridge_pattern(input logic dir, input logic [HALL_W-1:0] hall);
        logic [5:0] pat;
        pat = '0;
        if (!dir) begin
            case (hall)
                3'd1:    pat = SW_UL | SW_WH;
                3'd2:    pat = SW_VH | SW_WL;
                3'd3:    pat = SW_UL | SW_VH;
                3'd4:    pat = SW_UH | SW_VL;
                3'd5:    pat = SW_VL | SW_WH;
                3'd6:    pat = SW_UH | SW_WL;
                default: pat = '0;
            endcase
        end else begin
            case (hall)
                3'd1:    pat = SW_UH | SW_WL;
                3'd2:    pat = SW_VL | SW_WH;
                3'd3:    pat = SW_UH | SW_VL;
                3'd4:    pat = SW_UL | SW_VH;
                3'd5:    pat = SW_VH | SW_WL;
                3'd6:    pat = SW_UL | SW_WH;
                default: pat = '0;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

[sv/hall_sine_pwm_commutator.sv]
`timescale 1ns / 1ps
`default_nettype none

// hall edge with count in the step range: result via the div go, div wait and push states (bit-serial divider)
// tick: result via the rom read, 16x10 multiply and reciprocal scale states, then push
// other items: result registered from the push state; one item in flight, next taken once result is registered
// a stalled result transfer holds the push state and so holds the input off
// reset (aresetn low, synchronous): direction 0, phase 0, step 1, channels none, compares 0, low sides off

module hall_sine_pwm_commutator #(
    parameter int TABLE_ENTRIES      = 512,
    parameter int PWM_FULL_SCALE     = 1000,
    parameter int SINE_SCALE_PERCENT = 100
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire                            cfg_wdata,      // direction
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [hspc_pkg::S_DATA_W-1:0]  s_tdata,        // hall_state, elapsed_count, throttle
    input  wire  [hspc_pkg::CMD_W-1:0]     s_tuser,        // command
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // compare_w, compare_v, compare_u, low_u_level, low_v_level, low_w_level,
    // active_channel, measured_period, phase_index
    output logic [hspc_pkg::M_DATA_W-1:0]  m_tdata
);
    import hspc_pkg::*;

    localparam logic [PHASE_W-1:0] PhaseHalf    = PHASE_W'((TABLE_ENTRIES / 2) % (1 << PHASE_W));
    localparam logic [DIV_DW-1:0]  StepDividend = DIV_DW'(TABLE_ENTRIES * STEP_FACTOR);

    // floor(prod / full scale) as prod * ceil(2^shift / full scale) >> shift, exact for prod < 2^PROD_W
    localparam int              RecipShift = PROD_W + $clog2(PWM_FULL_SCALE);
    localparam int              RecipW     = PROD_W + 1;
    localparam int              ScaleW     = PROD_W + RecipW;
    localparam longint unsigned RecipDen   = 64'(PWM_FULL_SCALE);
    localparam logic [RecipW-1:0] Recip    =
        RecipW'(((64'd1 << RecipShift) + RecipDen - 64'd1) / RecipDen);

    state_t               state_reg, state_next;
    logic                 dir_reg, dir_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    chan_t                cur_reg, cur_next;
    chan_t                prev_reg, prev_next;
    logic [CMP_W-1:0]     cmp_w_reg, cmp_w_next;
    logic [CMP_W-1:0]     cmp_v_reg, cmp_v_next;
    logic [CMP_W-1:0]     cmp_u_reg, cmp_u_next;
    logic [2:0]           low_reg, low_next;
    logic [COUNT_W-1:0]   period_reg, period_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    logic [ENTRY_W-1:0]   rom_data;
    logic                 div_start;
    logic [DIV_DW-1:0]    div_dividend;
    logic [DIV_SW-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_DW-1:0]    div_quo;
    logic [ScaleW-1:0]    tick_prod;
    logic [CMP_W-1:0]     tick_width;

    logic [HALL_W-1:0]    in_hall;
    logic [COUNT_W-1:0]   in_count;
    logic [THR_W-1:0]     in_thr;
    logic [5:0]           pat;
    chan_t                chan_new;

    assign in_hall  = s_tdata[HALL_W-1:0];
    assign in_count = s_tdata[HALL_W+COUNT_W-1:HALL_W];
    assign in_thr   = s_tdata[HALL_W+COUNT_W+THR_W-1:HALL_W+COUNT_W];

    hspc_sine_rom #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .PWM_FULL_SCALE    (PWM_FULL_SCALE),
        .SINE_SCALE_PERCENT(SINE_SCALE_PERCENT)
    ) u_rom (
        .aclk   (aclk),
        .addr   (phase_reg),
        .rd_data(rom_data)
    );

    hspc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign div_dividend = StepDividend;
    assign div_divisor  = period_reg;

    assign tick_prod  = ScaleW'(prod_reg) * ScaleW'(Recip);
    assign tick_width = CMP_W'(tick_prod >> RecipShift);

    always_comb begin
        pat      = bridge_pattern(dir_reg, in_hall);
        chan_new = cur_reg;
        if ((pat & SW_UH) != '0 && (pat & SW_UL) == '0) chan_new = CH_U;
        if ((pat & SW_VH) != '0 && (pat & SW_VL) == '0) chan_new = CH_V;
        if ((pat & SW_WH) != '0 && (pat & SW_WL) == '0) chan_new = CH_W;
    end

    always_comb begin
        state_next   = state_reg;
        dir_next     = cfg_we ? cfg_wdata : dir_reg;
        thr_next     = thr_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        cmp_w_next   = cmp_w_reg;
        cmp_v_next   = cmp_v_reg;
        cmp_u_next   = cmp_u_reg;
        low_next     = low_reg;
        period_next  = period_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        s_tready     = (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    thr_next = in_thr;
                    case (cmd_t'(s_tuser))
                        CMD_HALL: begin
                            if ((pat & SW_UH) == '0) cmp_u_next = '0;
                            if ((pat & SW_VH) == '0) cmp_v_next = '0;
                            if ((pat & SW_WH) == '0) cmp_w_next = '0;
                            low_next    = {(pat & SW_WL) == '0, (pat & SW_VL) == '0,
                                           (pat & SW_UL) == '0};
                            cur_next    = chan_new;
                            period_next = in_count;
                            if (in_hall != 3'd0 && in_hall != 3'd7) begin
                                if (prev_reg != CH_NONE && prev_reg == chan_new)
                                    phase_next = PhaseHalf & PHASE_MASK;
                                else
                                    phase_next = '0;
                            end
                            if (in_count > STEP_LOWER && in_count < STEP_UPPER)
                                state_next = ST_DIV_GO;
                            else
                                state_next = ST_PUSH;
                        end
                        CMD_TICK: begin
                            phase_next = phase_reg + PHASE_W'(step_reg);
                            prev_next  = cur_reg;
                            state_next = ST_TICK_ROM;
                        end
                        CMD_TIMEOUT: begin
                            phase_next = '0;
                            cur_next   = CH_NONE;
                            prev_next  = CH_NONE;
                            state_next = ST_PUSH;
                        end
                        default: state_next = ST_PUSH;
                    endcase
                end
            end
            ST_TICK_ROM: state_next = ST_TICK_MUL;   // rom registers entry of new phase
            ST_TICK_MUL: begin
                prod_next  = PROD_W'(rom_data) * PROD_W'(thr_reg);
                state_next = ST_TICK_SCALE;
            end
            ST_TICK_SCALE: begin
                case (cur_reg)
                    CH_W:    cmp_w_next = tick_width;
                    CH_V:    cmp_v_next = tick_width;
                    CH_U:    cmp_u_next = tick_width;
                    default: ;
                endcase
                state_next = ST_PUSH;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (div_quo > DIV_DW'(STEP_MAX)) step_next = STEP_MAX;
                    else step_next = div_quo[STEP_W-1:0];
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, phase_reg, period_reg, cur_reg, low_reg,
                                    cmp_u_reg, cmp_v_reg, cmp_w_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dir_reg     <= 1'b0;
            phase_reg   <= '0;
            step_reg    <= STEP_W'(1);
            cur_reg     <= CH_NONE;
            prev_reg    <= CH_NONE;
            cmp_w_reg   <= '0;
            cmp_v_reg   <= '0;
            cmp_u_reg   <= '0;
            low_reg     <= 3'b111;
            period_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            cmp_w_reg   <= cmp_w_next;
            cmp_v_reg   <= cmp_v_next;
            cmp_u_reg   <= cmp_u_next;
            low_reg     <= low_next;
            period_reg  <= period_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        thr_reg    <= thr_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[sv/hspc_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none

module hspc_sine_rom #(
    parameter int TABLE_ENTRIES      = 512,
    parameter int PWM_FULL_SCALE     = 1000,
    parameter int SINE_SCALE_PERCENT = 100
) (
    input  wire                            aclk,
    input  wire  [hspc_pkg::PHASE_W-1:0]   addr,
    output logic [hspc_pkg::ENTRY_W-1:0]   rd_data
);
    import hspc_pkg::*;

    // only the first 512 entries are reachable by a 9-bit phase
    localparam int RomDepth = (TABLE_ENTRIES < (1 << PHASE_W)) ? TABLE_ENTRIES : (1 << PHASE_W);
    localparam int RomAw    = $clog2(RomDepth);

    localparam longint unsigned PiQ30     = 64'd3373259426;
    localparam longint unsigned OneQ30    = 64'd1073741824;
    localparam longint unsigned RoundDiv  = 64'd100 * OneQ30;
    localparam longint unsigned RoundHalf = 64'd50 * OneQ30;
    localparam longint unsigned Amp       = 64'(PWM_FULL_SCALE) * 64'(SINE_SCALE_PERCENT);
    localparam longint unsigned TaylorDiv [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

    // q2.30 taylor series of sin(i*pi/n), folded to the first quadrant
    function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned idx);
        longint unsigned i;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint          sum;
        i = 64'(idx);
        if (2 * i > 64'(TABLE_ENTRIES)) i = 64'(TABLE_ENTRIES) - i;
        x    = i * PiQ30 / 64'(TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < 8; k++) begin
            term = (term * x2) >> 30;
            term = term / TaylorDiv[k];
            if ((k % 2) == 0) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(OneQ30)) sum = longint'(OneQ30);
        s = longint'(sum);
        return ENTRY_W'((s * Amp + RoundHalf) / RoundDiv);
    endfunction

    logic [ENTRY_W-1:0] rom_tbl [RomDepth];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] rd_data_next;

    for (genvar g = 0; g < RomDepth; g++) begin : g_rom
        localparam logic [ENTRY_W-1:0] Entry = sine_entry(g);
        assign rom_tbl[g] = Entry;
    end

    always_comb begin
        if (32'(addr) < 32'(RomDepth)) rd_data_next = rom_tbl[addr[RomAw-1:0]];
        else rd_data_next = '0;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rd_data_next;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/hspc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module hspc_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [hspc_pkg::DIV_DW-1:0]  dividend,
    input  wire  [hspc_pkg::DIV_SW-1:0]  divisor,
    output logic                         done,
    output logic [hspc_pkg::DIV_DW-1:0]  quotient
);
    import hspc_pkg::*;

    localparam int CntW = $clog2(DIV_DW);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [DIV_SW-1:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0]   quo_reg, quo_next;
    logic [DIV_SW-1:0]   dsr_reg, dsr_next;
    logic [DIV_SW:0]     shifted;
    logic [DIV_SW:0]     trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[DIV_DW-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = trial[DIV_SW-1:0];
                quo_next = {quo_reg[DIV_DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_SW-1:0];
                quo_next = {quo_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DIV_DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import hspc_pkg::*;

    localparam int TABLE_N        = 512;
    localparam int FULL_SCALE     = 1000;
    localparam int SCALE_PCT      = 100;
    localparam int THR_MAX        = 1001;
    localparam int RAND_PER_PHASE = 172;
    localparam int NUM_PHASES     = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 4000;
    // hall codes in forward rotation order, lowest slot first
    localparam logic [17:0] HALL_SEQ = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    typedef struct packed {
        cmd_t                cmd;
        logic [HALL_W-1:0]   hall;
        logic [COUNT_W-1:0]  count;
        logic [THR_W-1:0]    throttle;
    } cmd_item_t;

    typedef struct {
        logic [CMP_W-1:0]    cmp_w;
        logic [CMP_W-1:0]    cmp_v;
        logic [CMP_W-1:0]    cmp_u;
        logic                lo_u;
        logic                lo_v;
        logic                lo_w;
        chan_t               chan;
        logic [COUNT_W-1:0]  period;
        logic [PHASE_W-1:0]  phase;
    } drive_state_t;

    class commutation_tracker;
        int unsigned         half_sine [TABLE_N];
        logic                dir;
        logic [PHASE_W-1:0]  phase_acc;
        logic [STEP_W-1:0]   step;
        chan_t               cur_ch;
        chan_t               prev_ch;
        logic [CMP_W-1:0]    cmp [3];
        logic [2:0]          low_off;
        logic [COUNT_W-1:0]  period;
        drive_state_t        pending_states [$];
        int                  fail_count;
        int                  items_seen;
        int                  results_checked;
        int                  edges_seen;
        int                  ticks_seen;

        function new();
            for (int i = 0; i < TABLE_N; i++) begin
                half_sine[i] = sine_point(i);
            end
            dir = 1'b0;
            phase_acc = '0;
            step = 1;
            cur_ch = CH_NONE;
            prev_ch = CH_NONE;
            cmp = '{default: '0};
            low_off = 3'b111;
            period = '0;
            fail_count = 0;
            items_seen = 0;
            results_checked = 0;
            edges_seen = 0;
            ticks_seen = 0;
        endfunction

        // q30 taylor series of sin over the folded angle, then scaled to pwm counts
        function int unsigned sine_point(int unsigned idx);
            longint unsigned i, x, x2, term, s;
            longint          sum;
            if (idx >= TABLE_N) return 0;
            i = idx;
            if (2 * i > TABLE_N) i = TABLE_N - i;
            x = i * 64'd3373259426 / TABLE_N;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > 64'sd1073741824) sum = 64'sd1073741824;
            s = sum;
            return int'((s * (FULL_SCALE * SCALE_PCT) + 50 * (64'd1 << 30))
                        / (100 * (64'd1 << 30)));
        endfunction

        function logic [5:0] bridge_switches(logic d, logic [HALL_W-1:0] h);
            logic [5:0] fwd [8];
            logic [5:0] bwd [8];
            fwd = '{6'h00, SW_UL | SW_WH, SW_VH | SW_WL, SW_UL | SW_VH,
                    SW_UH | SW_VL, SW_VL | SW_WH, SW_UH | SW_WL, 6'h00};
            bwd = '{6'h00, SW_UH | SW_WL, SW_VL | SW_WH, SW_UH | SW_VL,
                    SW_UL | SW_VH, SW_VH | SW_WL, SW_UL | SW_WH, 6'h00};
            return d ? bwd[h] : fwd[h];
        endfunction

        function void set_direction(logic d);
            dir = d;
        endfunction

        function void record_item(cmd_item_t it);
            drive_state_t e;
            logic [5:0]   pat;
            int unsigned  w;
            items_seen++;
            case (it.cmd)
                CMD_HALL: begin
                    edges_seen++;
                    pat = bridge_switches(dir, it.hall);
                    if ((pat & SW_UH) == 0) cmp[2] = '0;
                    if ((pat & SW_VH) == 0) cmp[1] = '0;
                    if ((pat & SW_WH) == 0) cmp[0] = '0;
                    low_off = {(pat & SW_WL) == 0, (pat & SW_VL) == 0, (pat & SW_UL) == 0};
                    if ((pat & SW_UH) != 0 && (pat & SW_UL) == 0) cur_ch = CH_U;
                    if ((pat & SW_VH) != 0 && (pat & SW_VL) == 0) cur_ch = CH_V;
                    if ((pat & SW_WH) != 0 && (pat & SW_WL) == 0) cur_ch = CH_W;
                    period = it.count;
                    if (it.count > STEP_LOWER && it.count < STEP_UPPER) begin
                        w = (TABLE_N * STEP_FACTOR) / it.count;
                        step = (w > STEP_MAX) ? STEP_MAX : w[STEP_W-1:0];
                    end
                    // same channel as the last tick restarts at mid table
                    if (it.hall != 3'd0 && it.hall != 3'd7) begin
                        if (prev_ch != CH_NONE && prev_ch == cur_ch)
                            phase_acc = PHASE_W'(TABLE_N / 2);
                        else
                            phase_acc = '0;
                    end
                end
                CMD_TICK: begin
                    ticks_seen++;
                    phase_acc = phase_acc + step;
                    w = (half_sine[phase_acc] * it.throttle) / FULL_SCALE;
                    if (cur_ch != CH_NONE) cmp[cur_ch - 1] = w[CMP_W-1:0];
                    prev_ch = cur_ch;
                end
                CMD_TIMEOUT: begin
                    phase_acc = '0;
                    cur_ch = CH_NONE;
                    prev_ch = CH_NONE;
                end
                default: ;
            endcase
            e.cmp_w = cmp[0];
            e.cmp_v = cmp[1];
            e.cmp_u = cmp[2];
            e.lo_u = low_off[0];
            e.lo_v = low_off[1];
            e.lo_w = low_off[2];
            e.chan = cur_ch;
            e.period = period;
            e.phase = phase_acc;
            pending_states.push_back(e);
        endfunction

        function bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
                return 0;
            end
            return 1;
        endfunction

        function void check_outputs(logic [M_DATA_W-1:0] word);
            drive_state_t e;
            bit           ok;
            if (pending_states.size() == 0) begin
                $display("%0t unexpected result transfer: expected none, actual %h", $time, word);
                fail_count++;
                return;
            end
            e = pending_states.pop_front();
            results_checked++;
            ok = 1;
            ok &= field_ok("compare_w", e.cmp_w, word[15:0]);
            ok &= field_ok("compare_v", e.cmp_v, word[31:16]);
            ok &= field_ok("compare_u", e.cmp_u, word[47:32]);
            ok &= field_ok("low_u_level", e.lo_u, word[48]);
            ok &= field_ok("low_v_level", e.lo_v, word[49]);
            ok &= field_ok("low_w_level", e.lo_w, word[50]);
            ok &= field_ok("active_channel", e.chan, word[52:51]);
            ok &= field_ok("measured_period", e.period, word[68:53]);
            ok &= field_ok("phase_index", e.phase, word[77:69]);
            if (!ok) fail_count++;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;

    commutation_tracker   tracker;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_off;
    int                   quiet_cycles;
    int                   rot_pos;
    logic                 cur_dir;

    hall_sine_pwm_commutator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_outputs(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cmd_item_t make_item(cmd_t c, int h, int cnt, int thr);
        cmd_item_t it;
        it.cmd = c;
        it.hall = h[HALL_W-1:0];
        it.count = cnt[COUNT_W-1:0];
        it.throttle = thr[THR_W-1:0];
        return it;
    endfunction

    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        r;
        it.hall = $urandom_range(7);
        it.count = $urandom_range(65535);
        it.throttle = $urandom_range(THR_MAX);
        r = $urandom_range(99);
        if (r < 25) begin
            it.cmd = CMD_HALL;
            // mostly follow the rotation order, otherwise any code
            if ($urandom_range(9) < 8) begin
                rot_pos = cur_dir ? (rot_pos + 5) % 6 : (rot_pos + 1) % 6;
                it.hall = HALL_SEQ[rot_pos*3 +: 3];
            end
            case ($urandom_range(9))
                0:       it.count = $urandom_range(100);
                1:       it.count = $urandom_range(65535, 15360);
                2, 3, 4: it.count = $urandom_range(400, 101);
                default: it.count = $urandom_range(15359, 101);
            endcase
        end else if (r < 88) begin
            it.cmd = CMD_TICK;
            if ($urandom_range(9) == 0) it.throttle = $urandom_range(1) ? THR_MAX : 0;
        end else if (r < 96) begin
            it.cmd = CMD_TIMEOUT;
        end else begin
            it.cmd = CMD_NOP;
        end
        return it;
    endfunction

    task automatic send_item(cmd_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {3'b000, it.throttle, it.count, it.hall};
        do @(posedge aclk); while (!s_tready);
        tracker.record_item(it);
    endtask

    task automatic write_direction(logic d);
        while (tracker.pending_states.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.set_direction(d);
    endtask

    initial begin
        tracker = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_NOP;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        quiet_cycles = 0;
        rot_pos = 0;
        cur_dir = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_direction(1'b0);
        send_item(make_item(CMD_NOP, 7, 65535, THR_MAX));
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));      // no channel yet
        send_item(make_item(CMD_HALL, 0, 0, 0));
        send_item(make_item(CMD_HALL, 7, 65535, 0));
        send_item(make_item(CMD_HALL, 1, 100, 0));          // count at lower bound, step kept
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));
        send_item(make_item(CMD_TICK, 7, 65535, 0));
        send_item(make_item(CMD_HALL, 1, 101, 0));          // same channel, mid table restart
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));
        send_item(make_item(CMD_HALL, 3, 15359, 0));
        send_item(make_item(CMD_TICK, 0, 0, 500));
        send_item(make_item(CMD_HALL, 2, 15360, 0));
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));
        send_item(make_item(CMD_HALL, 6, 102, 0));
        repeat (4) send_item(make_item(CMD_TICK, 0, 0, THR_MAX));   // phase wraps
        send_item(make_item(CMD_HALL, 4, 5000, 0));
        send_item(make_item(CMD_TICK, 0, 0, 1));
        send_item(make_item(CMD_HALL, 5, 150, 0));
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));
        send_item(make_item(CMD_TIMEOUT, 0, 0, 0));
        send_item(make_item(CMD_TICK, 0, 0, THR_MAX));
        send_item(make_item(CMD_HALL, 7, 200, 0));
        @(negedge aclk);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cur_dir = ((ph % 2) ^ ((ph / 2) % 2)) != 0;
            write_direction(cur_dir);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // long output hold-off while items keep coming
            if (ph == 0) hold_off = HOLD_CYCLES;
            for (int n = 0; n < RAND_PER_PHASE; n++) send_item(random_item());
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end

        while (tracker.pending_states.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("run covered %0d items (%0d hall edges, %0d pwm ticks), %0d results checked",
                 tracker.items_seen, tracker.edges_seen, tracker.ticks_seen,
                 tracker.results_checked);
        $display("both directions under four handshake stall mixes plus a long output hold-off");
        if (tracker.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/hspc_pkg.sv
sv/hspc_sine_rom.sv
sv/hspc_div.sv
sv/hall_sine_pwm_commutator.sv
tb/tb_top.sv
